@@ design/detl_pkg.sv @@
`default_nettype none

package detl_pkg;

    // Default list size; the top level takes it as a parameter (range 1 to 63)
    localparam int DEF_LIST_DEPTH = 16;

    // Field widths
    localparam int DELAY_W   = 31;
    localparam int TAG_W     = 8;
    localparam int ELAPSED_W = 20;
    localparam int SCALE_W   = 16;
    localparam int MAXD_W    = 20;
    localparam int DELTA_W   = 20;
    localparam int SDELTA_W  = 28;   // scaled delta: 20 bits times Q8.8, fraction dropped
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 20;
    localparam int KIND_W    = 2;

    // One list entry: scale flag, tag, remaining time
    localparam int ENTRY_W = 1 + TAG_W + DELAY_W;

    // Register reset values
    localparam logic [SCALE_W-1:0] TIME_SCALE_RST = 16'd256;
    localparam logic [MAXD_W-1:0]  MAX_DELTA_RST  = 20'd100000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA  = 1'b1;

    // Commands
    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_SCHEDULED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE = 2'd3;

endpackage

`default_nettype wire

@@ design/detl_ram.sv @@
`default_nettype none

module detl_ram
    import detl_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = DEF_LIST_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; a read of the address being
    // written returns the old contents
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ design/delayed_event_timer_list.sv @@
`default_nettype none

// Delayed event timer list. Holds up to LIST_DEPTH pending events in list
// order, each with a remaining time in microseconds, a scaled/unscaled flag
// and an 8-bit tag. A schedule transaction appends an event (or is rejected
// when the list is full) and returns one result in the cycle after
// acceptance. A tick transaction clamps its elapsed time to max_delta_us,
// forms the scaled delta (delta * time_scale >> 8, Q8.8) in the multiply
// state, then walks the list one entry per cycle through a list RAM with
// one write port and one registered read port, compacting survivors in
// place and stacking the tags of expired events. It then returns one fired
// result per expired event, in list order, and a final tick-done result;
// every result of a tick carries the pending count after the whole tick.
// s_ready stays low until the tick's last result has been loaded. The user
// must write configuration registers through cfg_wr_en / cfg_index /
// cfg_wdata only while the block is idle; the block does not enforce this.
module delayed_event_timer_list
    import detl_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH,
    parameter int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
    parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input transactions
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_command,
    input  wire logic [DELAY_W-1:0]    s_delay_us,
    input  wire logic                  s_use_scale,
    input  wire logic [TAG_W-1:0]      s_event_tag,
    input  wire logic [ELAPSED_W-1:0]  s_elapsed_us,
    // result transactions
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [KIND_W-1:0]     m_kind,
    output logic      [TAG_W-1:0]      m_fired_tag,
    output logic      [CNT_W-1:0]      m_active_count,
    output logic                       m_last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_WALK = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    logic [2:0]          state_reg,   state_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [IDX_W-1:0]    idx_reg,     idx_next;
    logic [CNT_W-1:0]    keep_reg,    keep_next;
    logic [CNT_W-1:0]    nfired_reg,  nfired_next;
    logic [CNT_W-1:0]    eidx_reg,    eidx_next;
    logic [DELTA_W-1:0]  delta_reg,   delta_next;
    logic [SDELTA_W-1:0] scaled_reg,  scaled_next;
    logic [SCALE_W-1:0]  scale_reg,   scale_next;
    logic [MAXD_W-1:0]   maxd_reg,    maxd_next;
    logic                m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]   m_kind_reg,  m_kind_next;
    logic [TAG_W-1:0]    m_tag_reg,   m_tag_next;
    logic [CNT_W-1:0]    m_count_reg, m_count_next;
    logic                m_last_reg,  m_last_next;

    logic                out_free;
    logic                accept;
    logic [DELTA_W+SCALE_W-1:0] product;

    // list RAM and fired-tag stack ports
    logic                e_wr_en;
    logic [IDX_W-1:0]    e_wr_addr;
    logic [ENTRY_W-1:0]  e_wr_data;
    logic [IDX_W-1:0]    e_rd_addr;
    logic [ENTRY_W-1:0]  e_rd_data;
    logic                f_wr_en;
    logic [IDX_W-1:0]    f_wr_addr;
    logic [IDX_W-1:0]    f_rd_addr;
    logic [TAG_W-1:0]    f_rd_data;

    // entry being walked
    logic                ent_flag;
    logic [TAG_W-1:0]    ent_tag;
    logic [DELAY_W-1:0]  ent_rem;
    logic [SDELTA_W-1:0] ent_delta;
    logic [DELAY_W:0]    diff;
    logic                expired;
    logic                last_entry;

    detl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIST_DEPTH),
        .AW    (IDX_W)
    ) u_list_ram (
        .aclk    (aclk),
        .wr_en   (e_wr_en),
        .wr_addr (e_wr_addr),
        .wr_data (e_wr_data),
        .rd_addr (e_rd_addr),
        .rd_data (e_rd_data)
    );

    detl_ram #(
        .WIDTH (TAG_W),
        .DEPTH (LIST_DEPTH),
        .AW    (IDX_W)
    ) u_fired_ram (
        .aclk    (aclk),
        .wr_en   (f_wr_en),
        .wr_addr (f_wr_addr),
        .wr_data (ent_tag),
        .rd_addr (f_rd_addr),
        .rd_data (f_rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    // multiplier for the scaled delta
    assign product = delta_reg * scale_reg;

    // unpack and update the entry under the walk
    assign ent_flag   = e_rd_data[ENTRY_W-1];
    assign ent_tag    = e_rd_data[ENTRY_W-2 -: TAG_W];
    assign ent_rem    = e_rd_data[DELAY_W-1:0];
    assign ent_delta  = ent_flag ? scaled_reg : SDELTA_W'(delta_reg);
    assign diff       = {1'b0, ent_rem} - (DELAY_W + 1)'(ent_delta);
    assign expired    = diff[DELAY_W] || (diff == '0);
    assign last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        keep_next    = keep_reg;
        nfired_next  = nfired_reg;
        eidx_next    = eidx_reg;
        delta_next   = delta_reg;
        scaled_next  = scaled_reg;
        scale_next   = scale_reg;
        maxd_next    = maxd_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_tag_next   = m_tag_reg;
        m_count_next = m_count_reg;
        m_last_next  = m_last_reg;

        e_wr_en   = 1'b0;
        e_wr_addr = count_reg[IDX_W-1:0];
        e_wr_data = {s_use_scale, s_event_tag, s_delay_us};
        e_rd_addr = '0;
        f_wr_en   = 1'b0;
        f_wr_addr = nfired_reg[IDX_W-1:0];
        f_rd_addr = '0;

        // take configuration writes
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TIME_SCALE: scale_next = cfg_wdata[SCALE_W-1:0];
                CFG_MAX_DELTA:  maxd_next  = cfg_wdata[MAXD_W-1:0];
                default:        ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_command == CMD_SCHEDULE) begin
                        // append, or reject when full; answer at once
                        m_valid_next = 1'b1;
                        m_tag_next   = '0;
                        m_last_next  = 1'b1;
                        if (count_reg < DEPTH_C) begin
                            e_wr_en      = 1'b1;
                            count_next   = count_reg + CNT_W'(1);
                            m_kind_next  = KIND_SCHEDULED;
                            m_count_next = count_reg + CNT_W'(1);
                        end else begin
                            m_kind_next  = KIND_REJECTED;
                            m_count_next = count_reg;
                        end
                    end else begin
                        // clamp the elapsed time
                        delta_next = (s_elapsed_us > maxd_reg) ? maxd_reg : s_elapsed_us;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                // form the scaled delta and fetch the first entry
                scaled_next = product[DELTA_W+SCALE_W-1:8];
                idx_next    = '0;
                keep_next   = '0;
                nfired_next = '0;
                e_rd_addr   = '0;
                state_next  = (count_reg == '0) ? ST_PREP : ST_WALK;
            end
            ST_WALK: begin
                // keep survivors compacted, stack expired tags
                if (expired) begin
                    f_wr_en     = 1'b1;
                    nfired_next = nfired_reg + CNT_W'(1);
                end else begin
                    e_wr_en   = 1'b1;
                    e_wr_addr = keep_reg[IDX_W-1:0];
                    e_wr_data = {ent_flag, ent_tag, diff[DELAY_W-1:0]};
                    keep_next = keep_reg + CNT_W'(1);
                end
                if (last_entry) begin
                    e_rd_addr  = idx_reg;
                    count_next = expired ? keep_reg : keep_reg + CNT_W'(1);
                    state_next = ST_PREP;
                end else begin
                    e_rd_addr = idx_reg + IDX_W'(1);
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end
            ST_PREP: begin
                // fetch the first stacked tag
                eidx_next  = '0;
                f_rd_addr  = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // hand out fired events, then the tick-done result
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_count_next = count_reg;
                    if (eidx_reg < nfired_reg) begin
                        m_kind_next = KIND_FIRED;
                        m_tag_next  = f_rd_data;
                        m_last_next = 1'b0;
                        eidx_next   = eidx_reg + CNT_W'(1);
                    end else begin
                        m_kind_next = KIND_TICK_DONE;
                        m_tag_next  = '0;
                        m_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                f_rd_addr = (eidx_next < DEPTH_C) ? eidx_next[IDX_W-1:0] : '0;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            scale_reg   <= TIME_SCALE_RST;
            maxd_reg    <= MAX_DELTA_RST;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            scale_reg   <= scale_next;
            maxd_reg    <= maxd_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        keep_reg    <= keep_next;
        nfired_reg  <= nfired_next;
        eidx_reg    <= eidx_next;
        delta_reg   <= delta_next;
        scaled_reg  <= scaled_next;
        m_kind_reg  <= m_kind_next;
        m_tag_reg   <= m_tag_next;
        m_count_reg <= m_count_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_fired_tag    = m_tag_reg;
    assign m_active_count = m_count_reg;
    assign m_last         = m_last_reg;

endmodule

`default_nettype wire

@@ design/detl_checker.sv @@
`default_nettype none

module detl_checker
    import detl_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH,
    parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [KIND_W-1:0] m_kind,
    input wire logic [TAG_W-1:0]  m_fired_tag,
    input wire logic [CNT_W-1:0]  m_active_count,
    input wire logic              m_last
);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_fired_tag)
            && $stable(m_active_count) && $stable(m_last))
        else $error("stalled result changed");

    // only a fired event leaves the transaction open
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_kind != KIND_FIRED)))
        else $error("last flag does not match result kind");

    // tag only on fired events
    a_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != KIND_FIRED) |-> (m_fired_tag == '0))
        else $error("tag on a result that is not a fired event");

    // reject only when full, never above the list size
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_active_count <= CNT_W'(LIST_DEPTH))
            && ((m_kind != KIND_REJECTED) || (m_active_count == CNT_W'(LIST_DEPTH))))
        else $error("pending count out of range");

    // results of one tick share the final count
    a_tick_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last ##1 m_valid |-> $stable(m_active_count))
        else $error("pending count changed within a tick");

endmodule

bind delayed_event_timer_list detl_checker #(
    .LIST_DEPTH (LIST_DEPTH),
    .CNT_W      (CNT_W)
) u_detl_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_kind         (m_kind),
    .m_fired_tag    (m_fired_tag),
    .m_active_count (m_active_count),
    .m_last         (m_last)
);

`default_nettype wire
